[hdl/ehsd_pkg.sv]
// Shared types, constants and helpers for the escape/hex stream decoder.
package ehsd_pkg;

  // Decoder phase between input bytes
  typedef enum logic [1:0] {
    PH_NORMAL    = 2'd0,
    PH_AFTER_ESC = 2'd1,
    PH_WANT_LOW  = 2'd2,
    PH_DISCARD   = 2'd3
  } phase_e;

  // One result transfer
  typedef struct packed {
    logic [7:0] plain_byte;
    logic       has_data;
    logic       is_error;
    logic       is_last;
  } result_t;

  // Escape character after reset
  localparam logic [7:0] EscResetVal = 8'h7E;

  // Control letters after an escape and the bytes they stand for
  localparam logic [7:0] LetterTab = 8'h49;  // 'I'
  localparam logic [7:0] LetterLf  = 8'h4A;  // 'J'
  localparam logic [7:0] LetterFf  = 8'h4C;  // 'L'
  localparam logic [7:0] LetterCr  = 8'h4D;  // 'M'
  localparam logic [7:0] ByteTab   = 8'h09;
  localparam logic [7:0] ByteLf    = 8'h0A;
  localparam logic [7:0] ByteFf    = 8'h0C;
  localparam logic [7:0] ByteCr    = 8'h0D;

  localparam logic [7:0] DigitZero = 8'h30;  // '0'
  localparam logic [7:0] LetterA   = 8'h41;  // 'A'
  localparam logic [3:0] NibbleTen = 4'd10;

  // Decode an uppercase hex digit: {bad, value}
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] diff;
    logic [4:0] res;
    res = {1'b1, 4'h0};
    if (c inside {[8'h30:8'h39]}) begin
      diff = c - DigitZero;
      res  = {1'b0, diff[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      diff = c - LetterA;
      res  = {1'b0, diff[3:0] + NibbleTen};
    end
    return res;
  endfunction

endpackage

[hdl/ehsd_decode.sv]
// Per-byte decode: next phase, held nibble and the result of one input byte.
module ehsd_decode (
  input  ehsd_pkg::phase_e  phase_i,
  input  logic [3:0]        nibble_i,
  input  logic [7:0]        esc_i,
  input  logic [7:0]        data_byte_i,
  input  logic              end_of_message_i,
  output ehsd_pkg::phase_e  phase_o,
  output logic [3:0]        nibble_o,
  output logic              res_valid_o,
  output ehsd_pkg::result_t res_o
);
  import ehsd_pkg::*;

  logic [4:0] hex;
  logic       hex_bad;
  logic       eom;

  assign hex     = hex_decode(data_byte_i);
  assign hex_bad = hex[4];
  assign eom     = end_of_message_i;

  // Phase transitions and result selection
  always_comb begin
    phase_o            = phase_i;
    nibble_o           = nibble_i;
    res_valid_o        = 1'b0;
    res_o.plain_byte   = 8'h00;
    res_o.has_data     = 1'b0;
    res_o.is_error     = 1'b0;
    res_o.is_last      = eom;
    case (phase_i)
      PH_NORMAL: begin
        if (data_byte_i != esc_i) begin
          res_valid_o      = 1'b1;
          res_o.plain_byte = data_byte_i;
          res_o.has_data   = 1'b1;
        end else if (eom) begin
          // escape cut short by end of message
          res_valid_o    = 1'b1;
          res_o.is_error = 1'b1;
        end else begin
          phase_o = PH_AFTER_ESC;
        end
      end
      PH_AFTER_ESC: begin
        phase_o = PH_NORMAL;
        if (data_byte_i == esc_i) begin
          res_valid_o      = 1'b1;
          res_o.plain_byte = data_byte_i;
          res_o.has_data   = 1'b1;
        end else if (data_byte_i == LetterTab || data_byte_i == LetterLf ||
                     data_byte_i == LetterFf || data_byte_i == LetterCr) begin
          res_valid_o    = 1'b1;
          res_o.has_data = 1'b1;
          case (data_byte_i)
            LetterTab: res_o.plain_byte = ByteTab;
            LetterLf:  res_o.plain_byte = ByteLf;
            LetterFf:  res_o.plain_byte = ByteFf;
            default:   res_o.plain_byte = ByteCr;
          endcase
        end else if (hex_bad) begin
          res_valid_o    = 1'b1;
          res_o.is_error = 1'b1;
          if (!eom) begin
            phase_o = PH_DISCARD;
          end
        end else if (eom) begin
          // first digit with no second one
          res_valid_o    = 1'b1;
          res_o.is_error = 1'b1;
        end else begin
          nibble_o = hex[3:0];
          phase_o  = PH_WANT_LOW;
        end
      end
      PH_WANT_LOW: begin
        phase_o     = PH_NORMAL;
        res_valid_o = 1'b1;
        if (hex_bad) begin
          res_o.is_error = 1'b1;
          if (!eom) begin
            phase_o = PH_DISCARD;
          end
        end else begin
          res_o.plain_byte = {nibble_i, hex[3:0]};
          res_o.has_data   = 1'b1;
        end
      end
      default: begin
        // drop bytes up to the end of the message
        if (eom) begin
          phase_o = PH_NORMAL;
        end
      end
    endcase
  end

endmodule

[hdl/escape_hex_stream_decoder.sv]
// Escape/hex stream decoder top level: phase register, result register and skid stage.
// A result is registered when its byte is accepted: in the result slot, or in the skid
// slot while output stalls. One byte is taken per cycle while the skid slot is empty.
// Bytes that end no sequence give no result transfer and only advance the phase.
// Reset: phase returns to pass-through, held nibble clears, escape character becomes 0x7E,
// and both result slots empty.
module escape_hex_stream_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       end_of_message_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] plain_byte_o,
  output logic       has_data_o,
  output logic       is_error_o,
  output logic       is_last_o
);
  import ehsd_pkg::*;

  logic [7:0] esc_q;
  phase_e     phase_q, phase_d;
  logic [3:0] nibble_q, nibble_d;
  logic       res_valid;
  result_t    res;
  result_t    out_q, skid_q;
  logic       out_valid_q, skid_valid_q;
  logic       in_fire, out_free;

  assign in_stall_o = skid_valid_q;
  assign in_fire    = in_valid_i && !skid_valid_q;
  assign out_free   = !out_valid_q || !out_stall_i;

  ehsd_decode u_decode (
    .phase_i          (phase_q),
    .nibble_i         (nibble_q),
    .esc_i            (esc_q),
    .data_byte_i      (data_byte_i),
    .end_of_message_i (end_of_message_i),
    .phase_o          (phase_d),
    .nibble_o         (nibble_d),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // Hold escape character and decode state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      esc_q    <= EscResetVal;
      phase_q  <= PH_NORMAL;
      nibble_q <= 4'h0;
    end else begin
      if (cfg_we_i) begin
        esc_q <= cfg_wdata_i;
      end
      if (in_fire) begin
        phase_q  <= phase_d;
        nibble_q <= nibble_d;
      end
    end
  end

  // Advance result and skid slots
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q <= in_fire && res_valid;
      end
    end else if (in_fire && res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Load result payloads
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (in_fire && res_valid) begin
        out_q <= res;
      end
    end else if (in_fire && res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign plain_byte_o = out_q.plain_byte;
  assign has_data_o   = out_q.has_data;
  assign is_error_o   = out_q.is_error;
  assign is_last_o    = out_q.is_last;

endmodule
